// ----- design/led_driver_chain_frame_builder_core_assert.svh -----
// assertion macros for the frame builder rtl
`ifndef LED_DRIVER_CHAIN_FRAME_BUILDER_CORE_ASSERT_SVH
`define LED_DRIVER_CHAIN_FRAME_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define LDCFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LDCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ldcfb_pkg.sv -----
`default_nettype none

package ldcfb_pkg;

    localparam int ACTION_W = 3;
    localparam int DEVICE_W = 3;
    localparam int DIGIT_W  = 3;
    localparam int VALUE_W  = 8;
    localparam int OPC_W    = 8;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 4;

    // chain geometry
    localparam logic [CFG_W-1:0]   MAX_CHAIN         = 4'd8;
    localparam int                 DIGITS_PER_DEVICE = 8;
    localparam logic [DIGIT_W-1:0] DIGIT_LAST        = DIGIT_W'(DIGITS_PER_DEVICE - 1);

    // opcodes and data limits
    localparam logic [OPC_W-1:0]   OPC_DIGIT_BASE   = 8'd1;
    localparam logic [OPC_W-1:0]   OPC_INTENSITY    = 8'd10;
    localparam logic [OPC_W-1:0]   OPC_SCANLIMIT    = 8'd11;
    localparam logic [OPC_W-1:0]   OPC_SHUTDOWN     = 8'd12;
    localparam logic [VALUE_W-1:0] SCAN_LIMIT_COUNT = 8'd8;
    localparam logic [VALUE_W-1:0] INTENSITY_COUNT  = 8'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_DIGIT  = 3'd0,
        ACT_CLEAR      = 3'd1,
        ACT_SHUTDOWN   = 3'd2,
        ACT_SCAN_LIMIT = 3'd3,
        ACT_INTENSITY  = 3'd4
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // decoded command
    typedef struct packed {
        logic              ok;
        logic              clear;
        logic [OPC_W-1:0]  opcode;
        logic [VALUE_W-1:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ----- design/ldcfb_in_if.sv -----
`default_nettype none

interface ldcfb_in_if;
    logic                              valid;
    logic                              ready;
    logic [ldcfb_pkg::ACTION_W-1:0]    action;
    logic [ldcfb_pkg::DEVICE_W-1:0]    device;
    logic [ldcfb_pkg::DIGIT_W-1:0]     digit;
    logic [ldcfb_pkg::VALUE_W-1:0]     value;

    modport source (output valid, action, device, digit, value, input ready);
    modport sink   (input valid, action, device, digit, value, output ready);
endinterface

`default_nettype wire

// ----- design/ldcfb_out_if.sv -----
`default_nettype none

interface ldcfb_out_if;
    logic                            valid;
    logic                            ready;
    logic [ldcfb_pkg::WORD_W-1:0]    word;
    logic                            frame_end;
    logic                            last;

    modport source (output valid, word, frame_end, last, input ready);
    modport sink   (input valid, word, frame_end, last, output ready);
endinterface

`default_nettype wire

// ----- design/ldcfb_cfg_if.sv -----
`default_nettype none

interface ldcfb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ldcfb_pkg::CFG_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/ldcfb_decode.sv -----
`default_nettype none

// checks one request against the chain and turns it into opcode and data
module ldcfb_decode (
    input  wire logic [ldcfb_pkg::ACTION_W-1:0] i_action,
    input  wire logic [ldcfb_pkg::DEVICE_W-1:0] i_device,
    input  wire logic [ldcfb_pkg::DIGIT_W-1:0]  i_digit,
    input  wire logic [ldcfb_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [ldcfb_pkg::CFG_W-1:0]    i_chain_len,
    output ldcfb_pkg::t_cmd                     o_cmd
);

    logic w_on_chain;

    assign w_on_chain = {1'b0, i_device} < i_chain_len;

    always_comb begin
        o_cmd.ok     = 1'b0;
        o_cmd.clear  = 1'b0;
        o_cmd.opcode = '0;
        o_cmd.data   = i_value;
        unique case (i_action)
            ldcfb_pkg::ACT_SET_DIGIT: begin
                o_cmd.ok     = ({1'b0, i_digit} < 4'(ldcfb_pkg::DIGITS_PER_DEVICE));
                o_cmd.opcode = ldcfb_pkg::OPC_DIGIT_BASE
                               + ldcfb_pkg::OPC_W'(i_digit);
            end
            ldcfb_pkg::ACT_CLEAR: begin
                // frame index is added per frame in the sequencer
                o_cmd.ok     = 1'b1;
                o_cmd.clear  = 1'b1;
                o_cmd.opcode = ldcfb_pkg::OPC_DIGIT_BASE;
                o_cmd.data   = '0;
            end
            ldcfb_pkg::ACT_SHUTDOWN: begin
                // nonzero flag means off, which is data zero
                o_cmd.ok     = 1'b1;
                o_cmd.opcode = ldcfb_pkg::OPC_SHUTDOWN;
                o_cmd.data   = ldcfb_pkg::VALUE_W'(i_value == '0);
            end
            ldcfb_pkg::ACT_SCAN_LIMIT: begin
                o_cmd.ok     = i_value < ldcfb_pkg::SCAN_LIMIT_COUNT;
                o_cmd.opcode = ldcfb_pkg::OPC_SCANLIMIT;
            end
            ldcfb_pkg::ACT_INTENSITY: begin
                o_cmd.ok     = i_value < ldcfb_pkg::INTENSITY_COUNT;
                o_cmd.opcode = ldcfb_pkg::OPC_INTENSITY;
            end
            default: begin
                o_cmd.ok = 1'b0;
            end
        endcase
        if (!w_on_chain) begin
            o_cmd.ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/led_driver_chain_frame_builder_core.sv -----
// Command frame builder for a daisy chain of 8-digit LED driver chips. Each
// request transfer on i_in (set digit, clear display, shutdown, scan limit or
// intensity for one chip) becomes one or more frames on o_out, one 16-bit word
// per transfer, opcode in the high byte and data in the low byte. A frame holds
// one word per chip on the chain, farthest chip first; the target chip gets the
// command and every other chip the no-op word zero. frame_end marks the word
// for chip 0, after which chip select should rise; last marks the final word
// of the request. Clear display sends eight frames, digit rows 0 to 7, all
// with data zero. A request for a chip beyond the chain, or with a digit, scan
// limit or intensity out of range, or an unknown action, is taken and gives
// no words. The chain length comes from the single configuration register
// (i_cfg, reset 8; 0 or more than 8 means 8), which the user must write only
// while idle; the block itself does not enforce this. A request is taken
// while idle, then words go out one per cycle, unless o_out stalls, from a
// single word builder (down counter over the chain, target compare, opcode
// adder) feeding an output register. i_in is not ready while a request is
// still being expanded; it is ready again once its last word has been loaded
// into the output register, even if that word is still waiting.
// No pattern history is kept, since no frame ever depends on earlier digits.
`default_nettype none

module led_driver_chain_frame_builder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ldcfb_cfg_if.sink  i_cfg,
    ldcfb_in_if.sink   i_in,
    ldcfb_out_if.source o_out
);

`include "led_driver_chain_frame_builder_core_assert.svh"

    // configuration
    logic [ldcfb_pkg::CFG_W-1:0]    r_num_devices;
    logic [ldcfb_pkg::CFG_W-1:0]    w_chain_len;

    // sequencer state
    ldcfb_pkg::t_state              r_state;
    ldcfb_pkg::t_state              n_state;
    logic                           w_in_ready;
    logic                           w_load;
    ldcfb_pkg::t_cmd                w_cmd;

    // current request, held while its frames go out
    logic [ldcfb_pkg::DEVICE_W-1:0] r_target;
    logic [ldcfb_pkg::OPC_W-1:0]    r_opcode;
    logic [ldcfb_pkg::VALUE_W-1:0]  r_data;
    logic                           r_clear;

    // position in the burst: chip counts down, frame counts up
    logic [ldcfb_pkg::DEVICE_W-1:0] r_dev;
    logic [ldcfb_pkg::DIGIT_W-1:0]  r_frame;

    // word builder
    logic [ldcfb_pkg::OPC_W-1:0]    w_opcode;
    logic [ldcfb_pkg::WORD_W-1:0]   w_word;
    logic                           w_frame_end;
    logic                           w_last_frame;
    logic                           w_word_last;

    // output register
    logic                           r_out_valid;
    logic [ldcfb_pkg::WORD_W-1:0]   r_word;
    logic                           r_frame_end;
    logic                           r_last;

    // chain length, out-of-range settings count as a full chain
    assign w_chain_len = (r_num_devices == '0 || r_num_devices > ldcfb_pkg::MAX_CHAIN)
                         ? ldcfb_pkg::MAX_CHAIN : r_num_devices;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_devices <= ldcfb_pkg::MAX_CHAIN;
        end else if (i_cfg.valid) begin
            r_num_devices <= i_cfg.data;
        end
    end

    ldcfb_decode u_decode (
        .i_action    (i_in.action),
        .i_device    (i_in.device),
        .i_digit     (i_in.digit),
        .i_value     (i_in.value),
        .i_chain_len (w_chain_len),
        .o_cmd       (w_cmd)
    );

    // one word per load: only the target chip gets the command
    assign w_opcode     = r_opcode + ldcfb_pkg::OPC_W'(r_frame);
    assign w_word       = (r_dev == r_target) ? {w_opcode, r_data} : '0;
    assign w_frame_end  = (r_dev == '0);
    assign w_last_frame = !r_clear || (r_frame == ldcfb_pkg::DIGIT_LAST);
    assign w_word_last  = w_frame_end && w_last_frame;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldcfb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ldcfb_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid && w_cmd.ok) begin
                    n_state = ldcfb_pkg::ST_EMIT;
                end
            end
            ldcfb_pkg::ST_EMIT: begin
                // build a word whenever the output register is free
                w_load = !r_out_valid || o_out.ready;
                if (w_load && w_word_last) begin
                    n_state = ldcfb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ldcfb_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // request capture and burst counters
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_target <= i_in.device;
            r_opcode <= w_cmd.opcode;
            r_data   <= w_cmd.data;
            r_clear  <= w_cmd.clear;
            r_dev    <= ldcfb_pkg::DEVICE_W'(w_chain_len - 1'b1);
            r_frame  <= '0;
        end else if (w_load) begin
            if (w_frame_end) begin
                // wrap to the farthest chip for the next frame
                r_dev   <= ldcfb_pkg::DEVICE_W'(w_chain_len - 1'b1);
                r_frame <= r_frame + 1'b1;
            end else begin
                r_dev <= r_dev - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word      <= w_word;
            r_frame_end <= w_frame_end;
            r_last      <= w_word_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.word      = r_word;
    assign o_out.frame_end = r_frame_end;
    assign o_out.last      = r_last;

    // checks
    `LDCFB_ASSERT_NOW(a_last_ends_frame, i_clk, i_rst_n,
        r_out_valid && r_last, r_frame_end, "last word does not close a frame")
    `LDCFB_ASSERT_NOW(a_dev_on_chain, i_clk, i_rst_n,
        r_state == ldcfb_pkg::ST_EMIT, {1'b0, r_dev} < w_chain_len,
        "chip counter beyond the chain")
    `LDCFB_ASSERT_NOW(a_single_frame, i_clk, i_rst_n,
        r_state == ldcfb_pkg::ST_EMIT && !r_clear, r_frame == '0,
        "frame counter moved on a single-frame request")
    `LDCFB_ASSERT_NEXT(a_accept_starts_burst, i_clk, i_rst_n,
        i_in.valid && w_in_ready && w_cmd.ok,
        r_state == ldcfb_pkg::ST_EMIT && r_dev == ldcfb_pkg::DEVICE_W'(w_chain_len - 1'b1),
        "accepted request did not start at the farthest chip")

endmodule

`default_nettype wire
